### design/prpdd_pkg.sv
// Shared types and constants for the PRP duplicate discard unit.
// Holds trailer constants, hash constants, verdict codes, state enums and
// the entry struct and the structs passed between the controller and entry table.
package prpdd_pkg;

   // Trailer recognition
   localparam logic [11:0] SIZE_MASK   = 12'hFFF;
   localparam logic [11:0] ETH_HDR_LEN = 12'd14;
   localparam logic [11:0] TRAILER_LEN = 12'd6;
   localparam logic [11:0] MIN_PRP_LEN = ETH_HDR_LEN + TRAILER_LEN;
   localparam logic [15:0] PRP_SUFFIX  = 16'h88FB;

   // Multiplicative hash constant, split into 32-bit halves
   localparam logic [31:0] HASH_HI = 32'h9E3779B9;
   localparam logic [31:0] HASH_LO = 32'h7F4A7C15;

   // Register reset value
   localparam logic [15:0] FORGET_RESET = 16'd400;

   // Stream word widths
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [1:0] {
      VERDICT_PASS_RAW = 2'd0,
      VERDICT_PASS_PRP = 2'd1,
      VERDICT_DROP     = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      HS_IDLE,
      HS_P0,
      HS_P1,
      HS_P2,
      HS_QUOT,
      HS_REM,
      HS_FIX
   } hash_state_type;

   typedef enum logic [1:0] {
      TB_CLEAR,
      TB_IDLE,
      TB_EVAL
   } table_state_type;

   typedef enum logic [1:0] {
      CT_IDLE,
      CT_HASH,
      CT_LOOKUP,
      CT_OUTPUT
   } ctrl_state_type;

   // One stored table entry
   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [1:0]  seen;
      logic [31:0] stamp;
   } entry_type;

   // Lookup request from controller to table
   typedef struct packed {
      logic        start;
      logic        port;
      logic [63:0] key;
      logic [31:0] now_ms;
      logic [15:0] forget;
   } tbl_req_type;

   // Table status back to controller
   typedef struct packed {
      logic        ready;
      logic        done;
      verdict_type verdict;
      logic        was_new;
   } tbl_status_type;

endpackage

### design/prp_duplicate_discard_unit.sv
// PRP duplicate discard unit: one verdict word per received frame summary.
// A non-PRP frame goes from accept through CT_OUTPUT to the output register; a PRP
// frame first takes a 6-step hash on a shared multiplier, then a memory
// read-modify-write. A new word is accepted only after the last one leaves CT_OUTPUT.
// Reset: synchronous; the table memory is then cleared one entry per cycle,
// and no request word is accepted until the clearing pass is done.
module prp_duplicate_discard_unit
   import prpdd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: rx_port
   input  logic                   req_tuser,
   // request: frame_length[11:0], trailer_size_word[27:12],
   // trailer_suffix[43:28], seq_num[59:44], source_mac[107:60],
   // now_ms[139:108], zero fill [143:140]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // response: verdict[1:0], entry_was_new[2], zero fill [7:3]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // forget_time_ms
   input  logic [15:0]            csr_data,
   input  logic                   csr_valid,
   output logic                   csr_ready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   ctrl_state_type state_ff, state_in;
   logic [63:0]    key_ff, key_in;
   logic           port_ff, port_in;
   logic [31:0]    now_ff, now_in;
   verdict_type    verdict_ff, verdict_in;
   logic           new_ff, new_in;
   logic           rsp_valid_ff, rsp_valid_in;
   verdict_type    rsp_verdict_ff, rsp_verdict_in;
   logic           rsp_new_ff, rsp_new_in;
   logic [15:0]    forget_ff;

   logic [11:0]    req_len;
   logic [15:0]    req_size;
   logic [15:0]    req_suffix;
   logic [15:0]    req_seq;
   logic [47:0]    req_mac;
   logic [31:0]    req_now;
   logic           is_prp;
   logic           accept;
   logic           load;

   logic           hash_start;
   logic           hash_done;
   logic [IDX_W-1:0] hash_slot;
   tbl_req_type    tbl_req;
   tbl_status_type tbl_status;

   // Unpack the request word
   assign req_len    = req_tdata[11:0];
   assign req_size   = req_tdata[27:12];
   assign req_suffix = req_tdata[43:28];
   assign req_seq    = req_tdata[59:44];
   assign req_mac    = req_tdata[107:60];
   assign req_now    = req_tdata[139:108];

   // Recognize a PRP trailer
   assign is_prp = (req_len > MIN_PRP_LEN)
                && ((req_size[11:0] & SIZE_MASK) == (req_len - ETH_HDR_LEN))
                && (req_suffix == PRP_SUFFIX);

   assign req_tready = (state_ff == CT_IDLE) && tbl_status.ready;
   assign accept     = req_tvalid && req_tready;

   // Frame sequencing: hash and lookup for PRP frames, then hand to the output register
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      port_in       = port_ff;
      now_in        = now_ff;
      verdict_in    = verdict_ff;
      new_in        = new_ff;
      hash_start    = 1'b0;
      load          = 1'b0;
      tbl_req.start  = 1'b0;
      tbl_req.port   = port_ff;
      tbl_req.key    = key_ff;
      tbl_req.now_ms = now_ff;
      tbl_req.forget = forget_ff;
      case (state_ff)
         CT_IDLE: begin
            if (accept) begin
               key_in  = {req_mac, req_seq};
               port_in = req_tuser;
               now_in  = req_now;
               if (is_prp) begin
                  hash_start = 1'b1;
                  state_in   = CT_HASH;
               end else begin
                  verdict_in = VERDICT_PASS_RAW;
                  new_in     = 1'b0;
                  state_in   = CT_OUTPUT;
               end
            end
         end
         CT_HASH: begin
            if (hash_done) begin
               tbl_req.start = 1'b1;
               state_in      = CT_LOOKUP;
            end
         end
         CT_LOOKUP: begin
            if (tbl_status.done) begin
               verdict_in = tbl_status.verdict;
               new_in     = tbl_status.was_new;
               state_in   = CT_OUTPUT;
            end
         end
         CT_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = CT_IDLE;
            end
         end
         default: begin
            state_in = CT_IDLE;
         end
      endcase
   end

   // Output register: hold until taken, load when free
   assign rsp_valid_in   = load || (rsp_valid_ff && !rsp_tready);
   assign rsp_verdict_in = load ? verdict_ff : rsp_verdict_ff;
   assign rsp_new_in     = load ? new_ff : rsp_new_ff;

   // Control registers and forget time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CT_IDLE;
         rsp_valid_ff <= 1'b0;
         forget_ff    <= FORGET_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            forget_ff <= csr_data;
         end
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      port_ff        <= port_in;
      now_ff         <= now_in;
      verdict_ff     <= verdict_in;
      new_ff         <= new_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_new_ff     <= rsp_new_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_new_ff, rsp_verdict_ff};

   prpdd_hash #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   ({req_mac, req_seq}),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   prpdd_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .slot   (hash_slot),
      .req    (tbl_req),
      .status (tbl_status)
   );

   // Hash completes only while the controller waits for it
   a_hash_in_step: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == CT_HASH))
      else $error("hash completion outside hash step");

   // Table results arrive only while a lookup is pending
   a_lookup_in_step: assert property (@(posedge clock) disable iff (reset)
      tbl_status.done |-> (state_ff == CT_LOOKUP))
      else $error("table result outside lookup step");

   // Non-PRP words never report a new entry
   a_raw_not_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_verdict_ff == VERDICT_PASS_RAW)) |-> !rsp_new_ff)
      else $error("non-PRP word marked as new entry");

endmodule

### design/prpdd_hash.sv
// Slot hash unit: multiplicative hash of the 64-bit key, reduced modulo the
// table depth, on one shared 32x32 multiplier. Depends on prpdd_pkg.
module prpdd_hash
   import prpdd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [63:0]                      key,
   output logic                             done,
   output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   // floor(2^32 / depth): quotient estimate is low by at most one
   localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(TABLE_ENTRIES);
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
   localparam logic [31:0] DIVISOR    = 32'(TABLE_ENTRIES);

   hash_state_type   state_ff, state_in;
   logic [63:0]      key_ff, key_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      quot_ff, quot_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             done_ff, done_in;
   logic [31:0]      mult_a, mult_b;
   logic [63:0]      prod;
   logic [31:0]      rem;

   // Shared multiplier
   assign prod = 64'(mult_a) * 64'(mult_b);

   // Final correction of the remainder
   assign rem = (acc_ff >= DIVISOR) ? (acc_ff - DIVISOR) : acc_ff;

   // Sequence partial products, then quotient, remainder and correction
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      acc_in   = acc_ff;
      quot_in  = quot_ff;
      slot_in  = slot_ff;
      done_in  = 1'b0;
      mult_a   = '0;
      mult_b   = '0;
      case (state_ff)
         HS_IDLE: begin
            if (start) begin
               key_in   = key;
               state_in = HS_P0;
            end
         end
         HS_P0: begin
            mult_a   = key_ff[31:0];
            mult_b   = HASH_LO;
            acc_in   = prod[63:32];
            state_in = HS_P1;
         end
         HS_P1: begin
            mult_a   = key_ff[63:32];
            mult_b   = HASH_LO;
            acc_in   = acc_ff + prod[31:0];
            state_in = HS_P2;
         end
         HS_P2: begin
            mult_a   = key_ff[31:0];
            mult_b   = HASH_HI;
            acc_in   = acc_ff + prod[31:0];
            state_in = HS_QUOT;
         end
         HS_QUOT: begin
            mult_a   = acc_ff;
            mult_b   = RECIP;
            quot_in  = prod[63:32];
            state_in = HS_REM;
         end
         HS_REM: begin
            mult_a   = quot_ff;
            mult_b   = DIVISOR;
            acc_in   = acc_ff - prod[31:0];
            state_in = HS_FIX;
         end
         HS_FIX: begin
            slot_in  = rem[IDX_W-1:0];
            done_in  = 1'b1;
            state_in = HS_IDLE;
         end
         default: begin
            state_in = HS_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

   // Completion is a single-cycle pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("hash done held longer than one cycle");

   // Reported slot lies inside the table
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (32'(slot_ff) < DIVISOR))
      else $error("hash slot outside table");

   // Estimated remainder needs at most one correction
   a_fix_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == HS_FIX) |-> (33'(acc_ff) < (33'(DIVISOR) << 1)))
      else $error("remainder estimate out of correction range");

endmodule

### design/prpdd_table.sv
// Entry table: one synchronous memory of entries with a clearing pass after
// reset and a read-modify-write per lookup. Depends on prpdd_pkg.
module prpdd_table
   import prpdd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] slot,
   input  tbl_req_type                      req,
   output tbl_status_type                   status
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   entry_type        mem [TABLE_ENTRIES];
   entry_type        rd_ff;

   table_state_type  state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   tbl_req_type      req_ff, req_in;
   logic             done_ff, done_in;
   verdict_type      verdict_ff, verdict_in;
   logic             new_ff, new_in;

   logic             we;
   logic [IDX_W-1:0] waddr;
   entry_type        wdata;
   logic             rd_en;

   logic [1:0]       own;
   logic [1:0]       other;
   logic             hit;
   logic [1:0]       seen;
   logic [31:0]      delta;
   logic             drop;

   // Evaluate the entry read for the pending frame
   assign own   = req_ff.port ? 2'b10 : 2'b01;
   assign other = {own[0], own[1]};
   assign hit   = rd_ff.valid && (rd_ff.key == req_ff.key);
   assign seen  = rd_ff.seen | own;
   assign delta = req_ff.now_ms - rd_ff.stamp;
   assign drop  = hit && ((seen & other) != 2'b00) && (delta < {16'd0, req_ff.forget});

   // Clear, read and write-back sequencing
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      slot_in    = slot_ff;
      req_in     = req_ff;
      done_in    = 1'b0;
      verdict_in = verdict_ff;
      new_in     = new_ff;
      we         = 1'b0;
      waddr      = slot_ff;
      wdata      = '0;
      rd_en      = 1'b0;
      case (state_ff)
         TB_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = TB_IDLE;
            end
         end
         TB_IDLE: begin
            if (req.start) begin
               rd_en    = 1'b1;
               slot_in  = slot;
               req_in   = req;
               state_in = TB_EVAL;
            end
         end
         TB_EVAL: begin
            we          = 1'b1;
            wdata.valid = 1'b1;
            wdata.key   = req_ff.key;
            if (hit) begin
               wdata.seen  = seen;
               wdata.stamp = drop ? rd_ff.stamp : req_ff.now_ms;
               verdict_in  = drop ? VERDICT_DROP : VERDICT_PASS_PRP;
               new_in      = 1'b0;
            end else begin
               wdata.seen  = own;
               wdata.stamp = req_ff.now_ms;
               verdict_in  = VERDICT_PASS_PRP;
               new_in      = 1'b1;
            end
            done_in  = 1'b1;
            state_in = TB_IDLE;
         end
         default: begin
            state_in = TB_IDLE;
         end
      endcase
   end

   // Entry memory, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= mem[slot];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TB_CLEAR;
         clr_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         done_ff  <= done_in;
      end
   end

   // Pending request and result registers
   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      req_ff     <= req_in;
      verdict_ff <= verdict_in;
      new_ff     <= new_in;
   end

   assign status.ready   = (state_ff == TB_IDLE);
   assign status.done    = done_ff;
   assign status.verdict = verdict_ff;
   assign status.was_new = new_ff;

   // A result only follows a write-back cycle
   a_done_after_eval: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(state_ff) == TB_EVAL))
      else $error("table result without write-back");

   // A dropped frame always hit an existing entry
   a_drop_not_new: assert property (@(posedge clock) disable iff (reset)
      (done_ff && (verdict_ff == VERDICT_DROP)) |-> !new_ff)
      else $error("drop reported on a new entry");

   // Lookups arrive only while the table is idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> (state_ff == TB_IDLE))
      else $error("lookup started while table busy");

endmodule
